[hw/rtl/haptic_belt_motor_mixer_macros.svh]
`ifndef HAPTIC_BELT_MOTOR_MIXER_MACROS_SVH
`define HAPTIC_BELT_MOTOR_MIXER_MACROS_SVH

// same-cycle check: when ante holds, cons must hold too
`define HBMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check: when ante holds, cons must hold in the next cycle
`define HBMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hbmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hbmm_pkg;

    // default width of the wrapping time base
    localparam int TIME_BITS_DEF = 32;

    localparam int MOTOR_COUNT = 5;
    localparam int MOTOR_BITS  = 3;
    localparam logic [MOTOR_BITS-1:0] NO_MOTOR = MOTOR_BITS'(5);

    // belt motor headings in degrees
    localparam int MOTOR_ANGLE_0 = 36;
    localparam int MOTOR_ANGLE_1 = 108;
    localparam int MOTOR_ANGLE_2 = 180;
    localparam int MOTOR_ANGLE_3 = 252;
    localparam int MOTOR_ANGLE_4 = 324;
    localparam int FULL_TURN     = 360;

    // sector upper bounds, inclusive: a tie at the midpoint goes to the lower motor
    localparam logic [8:0] SECTOR_TOP_0 = 9'((MOTOR_ANGLE_0 + MOTOR_ANGLE_1) / 2);
    localparam logic [8:0] SECTOR_TOP_1 = 9'((MOTOR_ANGLE_1 + MOTOR_ANGLE_2) / 2);
    localparam logic [8:0] SECTOR_TOP_2 = 9'((MOTOR_ANGLE_2 + MOTOR_ANGLE_3) / 2);
    localparam logic [8:0] SECTOR_TOP_3 = 9'((MOTOR_ANGLE_3 + MOTOR_ANGLE_4) / 2);

    // configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLINK_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBSTACLE_HOLD     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBSTACLE_LIMIT    = 2'd2;

    localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd1000;
    localparam logic [15:0] OBSTACLE_HOLD_RST     = 16'd1000;
    localparam logic [14:0] OBSTACLE_LIMIT_RST    = 15'd1000;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_opcode;

endpackage

`default_nettype wire

[hw/rtl/hbmm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface hbmm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic signed [15:0] target_angle;
    logic [31:0] now_ms;
    logic signed [15:0] sensor_a_distance_mm;
    logic signed [15:0] sensor_b_distance_mm;

    modport source (
        output valid, opcode, target_angle, now_ms,
               sensor_a_distance_mm, sensor_b_distance_mm,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_angle, now_ms,
               sensor_a_distance_mm, sensor_b_distance_mm,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/hbmm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface hbmm_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] motor_drive;
    logic       nav_pulse_on;
    logic       obstacle_active;
    logic [2:0] nav_motor_index;

    modport source (
        output valid, motor_drive, nav_pulse_on, obstacle_active, nav_motor_index,
        input  ready
    );
    modport sink (
        input  valid, motor_drive, nav_pulse_on, obstacle_active, nav_motor_index,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/hbmm_heading.sv]
`timescale 1ns / 1ps
`default_nettype none

// wraps a signed heading into 0..359 and picks the nearest belt motor
module hbmm_heading (
    input  wire logic signed [15:0]               i_angle,
    output logic [hbmm_pkg::MOTOR_BITS-1:0]        o_motor
);

    // bias by a multiple of 360 so the value is never negative
    localparam logic [16:0] BIAS  = 17'(92 * hbmm_pkg::FULL_TURN);
    // ceil(2^24 / 360): exact quotient for every biased value, 352..65887
    localparam int          SHIFT = 24;
    localparam logic [16:0] RECIP = 17'(((1 << SHIFT) + hbmm_pkg::FULL_TURN - 1)
                                        / hbmm_pkg::FULL_TURN);

    logic [16:0] biased;
    logic [33:0] prod;
    logic [7:0]  quot;
    logic [16:0] quot_x360;
    logic [16:0] rem_full;
    logic [8:0]  wrapped;

    // modulo 360 by reciprocal multiply
    assign biased    = {i_angle[15], i_angle} + BIAS;
    assign prod      = 34'(biased) * 34'(RECIP);
    assign quot      = prod[SHIFT+7:SHIFT];
    assign quot_x360 = (17'(quot) << 8) + (17'(quot) << 6) + (17'(quot) << 5)
                     + (17'(quot) << 3);
    assign rem_full  = biased - quot_x360;
    assign wrapped   = rem_full[8:0];

    // sector select, lower motor wins on the boundary
    always_comb begin
        priority if (wrapped <= hbmm_pkg::SECTOR_TOP_0) begin
            o_motor = hbmm_pkg::MOTOR_BITS'(0);
        end else if (wrapped <= hbmm_pkg::SECTOR_TOP_1) begin
            o_motor = hbmm_pkg::MOTOR_BITS'(1);
        end else if (wrapped <= hbmm_pkg::SECTOR_TOP_2) begin
            o_motor = hbmm_pkg::MOTOR_BITS'(2);
        end else if (wrapped <= hbmm_pkg::SECTOR_TOP_3) begin
            o_motor = hbmm_pkg::MOTOR_BITS'(3);
        end else begin
            o_motor = hbmm_pkg::MOTOR_BITS'(hbmm_pkg::MOTOR_COUNT - 1);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/haptic_belt_motor_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "haptic_belt_motor_mixer_macros.svh"
// an accepted word passes the input register and then the result register (2 registers)
// throughput: one word per cycle; input register and result register stall together
// on a full result register that is not being taken
// reset (i_rst_n low, synchronous): navigation stopped, no motor, time marks zero,
// configuration back to 1000 ms / 1000 ms / 1000 mm, both channels empty

module haptic_belt_motor_mixer #(
    parameter int TIME_BITS = hbmm_pkg::TIME_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    hbmm_in_if.sink                                 i_in,
    hbmm_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [hbmm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [hbmm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int MB = hbmm_pkg::MOTOR_BITS;

    // configuration registers
    logic [15:0] r_cfg_half;
    logic [15:0] r_cfg_hold;
    logic [14:0] r_cfg_limit;

    // input register
    logic                r_in_valid;
    logic [1:0]          r_in_opcode;
    logic signed [15:0]  r_in_angle;
    logic [31:0]         r_in_now;
    logic signed [15:0]  r_in_dist_a;
    logic signed [15:0]  r_in_dist_b;

    // tick state
    logic                 r_nav_run,    n_nav_run;
    logic                 r_nav_phase,  n_nav_phase;
    logic [TIME_BITS-1:0] r_nav_toggle, n_nav_toggle;
    logic [MB-1:0]        r_nav_motor,  n_nav_motor;
    logic [TIME_BITS-1:0] r_trig_a,     n_trig_a;
    logic [TIME_BITS-1:0] r_trig_b,     n_trig_b;

    // result register
    logic          r_out_valid;
    logic [4:0]    r_out_drive,  n_out_drive;
    logic          r_out_pulse,  n_out_pulse;
    logic          r_out_obst,   n_out_obst;
    logic [MB-1:0] r_out_motor;

    logic                 advance;
    logic                 fire;
    logic                 in_ready;
    logic [MB-1:0]        sel_motor;
    logic [TIME_BITS-1:0] now_t;
    logic                 hit_a;
    logic                 hit_b;

    assign advance  = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && advance;
    assign in_ready = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_half  <= hbmm_pkg::BLINK_HALF_PERIOD_RST;
            r_cfg_hold  <= hbmm_pkg::OBSTACLE_HOLD_RST;
            r_cfg_limit <= hbmm_pkg::OBSTACLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hbmm_pkg::CFG_BLINK_HALF_PERIOD: r_cfg_half  <= i_cfg_data;
                hbmm_pkg::CFG_OBSTACLE_HOLD:     r_cfg_hold  <= i_cfg_data;
                hbmm_pkg::CFG_OBSTACLE_LIMIT:    r_cfg_limit <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_opcode <= i_in.opcode;
            r_in_angle  <= i_in.target_angle;
            r_in_now    <= i_in.now_ms;
            r_in_dist_a <= i_in.sensor_a_distance_mm;
            r_in_dist_b <= i_in.sensor_b_distance_mm;
        end
    end

    hbmm_heading u_heading (
        .i_angle (r_in_angle),
        .o_motor (sel_motor)
    );

    assign now_t = TIME_BITS'(r_in_now);
    assign hit_a = !r_in_dist_a[15] && (r_in_dist_a != 16'sd0)
                   && (r_in_dist_a[14:0] < r_cfg_limit);
    assign hit_b = !r_in_dist_b[15] && (r_in_dist_b != 16'sd0)
                   && (r_in_dist_b[14:0] < r_cfg_limit);

    // one tick: command, blink toggle, sensor retrigger, output mix
    always_comb begin
        logic                 a_on;
        logic                 b_on;
        logic [TIME_BITS-1:0] since_toggle;
        logic [TIME_BITS-1:0] since_a;
        logic [TIME_BITS-1:0] since_b;

        n_nav_run    = r_nav_run;
        n_nav_phase  = r_nav_phase;
        n_nav_toggle = r_nav_toggle;
        n_nav_motor  = r_nav_motor;

        unique case (r_in_opcode)
            hbmm_pkg::OP_START: begin
                n_nav_run    = 1'b1;
                n_nav_motor  = sel_motor;
                n_nav_phase  = 1'b1;
                n_nav_toggle = now_t;
            end
            hbmm_pkg::OP_STOP: begin
                n_nav_run   = 1'b0;
                n_nav_motor = hbmm_pkg::NO_MOTOR;
            end
            default: ;
        endcase

        since_toggle = now_t - n_nav_toggle;
        if (n_nav_run && (since_toggle >= TIME_BITS'(r_cfg_half))) begin
            n_nav_phase  = !n_nav_phase;
            n_nav_toggle = now_t;
        end

        n_trig_a = hit_a ? now_t : r_trig_a;
        n_trig_b = hit_b ? now_t : r_trig_b;

        since_a = now_t - n_trig_a;
        since_b = now_t - n_trig_b;
        a_on    = since_a < TIME_BITS'(r_cfg_hold);
        b_on    = since_b < TIME_BITS'(r_cfg_hold);

        n_out_pulse = n_nav_run && n_nav_phase
                      && (n_nav_motor < MB'(hbmm_pkg::MOTOR_COUNT));
        n_out_drive = 5'd0;
        if (n_out_pulse) begin
            n_out_drive = 5'd1 << n_nav_motor;
        end
        n_out_drive[0] = n_out_drive[0] | a_on;
        n_out_drive[4] = n_out_drive[4] | b_on;
        n_out_obst     = a_on || b_on;
    end

    // tick state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nav_run    <= 1'b0;
            r_nav_phase  <= 1'b0;
            r_nav_toggle <= '0;
            r_nav_motor  <= hbmm_pkg::NO_MOTOR;
            r_trig_a     <= '0;
            r_trig_b     <= '0;
        end else if (fire) begin
            r_nav_run    <= n_nav_run;
            r_nav_phase  <= n_nav_phase;
            r_nav_toggle <= n_nav_toggle;
            r_nav_motor  <= n_nav_motor;
            r_trig_a     <= n_trig_a;
            r_trig_b     <= n_trig_b;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_drive <= n_out_drive;
            r_out_pulse <= n_out_pulse;
            r_out_obst  <= n_out_obst;
            r_out_motor <= n_nav_motor;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.motor_drive     = r_out_drive;
    assign o_out.nav_pulse_on    = r_out_pulse;
    assign o_out.obstacle_active = r_out_obst;
    assign o_out.nav_motor_index = r_out_motor;

    // checks
    `HBMM_ASSERT_NOW(a_run_has_motor, i_clk, i_rst_n, 1'b1,
        r_nav_run == (r_nav_motor != hbmm_pkg::NO_MOTOR), "run flag and motor disagree")
    `HBMM_ASSERT_NOW(a_obst_drives, i_clk, i_rst_n, r_out_valid && r_out_obst,
        r_out_drive[0] || r_out_drive[4], "obstacle active without its motor")
    `HBMM_ASSERT_NEXT(a_fire_fills, i_clk, i_rst_n, fire, r_out_valid,
        "computed word not held in result register")

endmodule

`default_nettype wire
